// ===== sv/rpcoct_pkg.sv =====
// ----------------------------------------------------------------------------
// RPC outstanding call tracker: shared package
// Types, codes and reset constants used by the tracker and its slot logic.
// ----------------------------------------------------------------------------
package rpcoct_pkg;

    // Default number of call slots in the table.
    localparam int SLOTS_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RETX_AFTER_RST = 8'd8;
    localparam logic [7:0]  MAX_RETX_RST   = 8'd60;
    localparam logic [31:0] XID_SEED_RST   = 32'd0;

    // All-ones word reported on timeouts and rejected replies.
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  TIMER_TOP = 8'hFF;

    // Command codes carried on the input side.
    localparam logic [1:0] CMD_ISSUE = 2'd0;
    localparam logic [1:0] CMD_MSG   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    // Header error codes.
    localparam logic [1:0] HERR_NONE  = 2'd0;
    localparam logic [1:0] HERR_SHORT = 2'd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_RETX_AFTER = 2'd0;
    localparam logic [1:0] REG_MAX_RETX   = 2'd1;
    localparam logic [1:0] REG_XID_SEED   = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_ISSUED    = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_COMPLETED = 3'd2;
    localparam logic [2:0] KIND_MALFORMED = 3'd3;
    localparam logic [2:0] KIND_UNKNOWN   = 3'd4;
    localparam logic [2:0] KIND_DROPPED   = 3'd5;
    localparam logic [2:0] KIND_RETX      = 3'd6;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd7;

    // One stored call.
    typedef struct packed {
        logic [31:0] xid;
        logic [15:0] tag;
        logic [7:0]  timer;
        logic [7:0]  retries;
    } t_slot_entry;

    // One result item.
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] xid;
        logic [15:0] tag;
        logic [31:0] status;
        logic [31:0] accept;
        logic        accept_valid;
    } t_result;

    // Decision of the slot unit for the slot under evaluation.
    typedef struct packed {
        logic        has_res;
        logic        stop;
        logic        wr_en;
        logic        set_valid;
        logic        clr_valid;
        t_slot_entry wr_entry;
        t_result     res;
    } t_slot_act;

    function automatic t_result mk_result(
        input logic [2:0]  kind,
        input logic [31:0] xid,
        input logic [15:0] tag,
        input logic [31:0] status,
        input logic [31:0] accept,
        input logic        accept_valid
    );
        t_result r;
        r.kind         = kind;
        r.xid          = xid;
        r.tag          = tag;
        r.status       = status;
        r.accept       = accept;
        r.accept_valid = accept_valid;
        return r;
    endfunction

endpackage

// ===== sv/rpcoct_slot_ram.sv =====
// ----------------------------------------------------------------------------
// RPC outstanding call tracker: slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rpcoct_slot_ram #(
    parameter int DEPTH = rpcoct_pkg::SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  rpcoct_pkg::t_slot_entry  i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output rpcoct_pkg::t_slot_entry  o_rd_data
);

    rpcoct_pkg::t_slot_entry r_mem [DEPTH];
    rpcoct_pkg::t_slot_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds while no read is requested.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/rpcoct_slot_unit.sv =====
// ----------------------------------------------------------------------------
// RPC outstanding call tracker: slot unit
// Compare and update logic applied to one slot per cycle while a walk is not stalled.
// ----------------------------------------------------------------------------
module rpcoct_slot_unit (
    input  logic [1:0]              i_op,
    input  logic                    i_slot_valid,
    input  rpcoct_pkg::t_slot_entry i_entry,
    input  logic                    i_last,
    input  logic [31:0]             i_xid_issue,
    input  logic [15:0]             i_tag,
    input  logic [31:0]             i_mxid,
    input  logic [31:0]             i_rstat,
    input  logic [31:0]             i_astat,
    input  logic [1:0]              i_herr,
    input  logic [7:0]              i_retx_after,
    input  logic [7:0]              i_max_retx,
    output rpcoct_pkg::t_slot_act   o_act
);

    logic [7:0] w_timer_inc;
    logic       w_due;
    logic       w_expired;
    logic       w_match;

    // Saturating timer step and the due and limit compares.
    assign w_timer_inc = (i_entry.timer == rpcoct_pkg::TIMER_TOP) ?
                         rpcoct_pkg::TIMER_TOP : i_entry.timer + 8'd1;
    assign w_due       = (w_timer_inc >= i_retx_after);
    assign w_expired   = (i_entry.retries >= i_max_retx);
    assign w_match     = i_slot_valid && (i_entry.xid == i_mxid);

    always_comb begin
        o_act           = '0;
        o_act.wr_entry  = i_entry;
        case (i_op)
            rpcoct_pkg::CMD_ISSUE: begin
                // First free slot takes the call; a full table reports at the end.
                if (!i_slot_valid) begin
                    o_act.has_res   = 1'b1;
                    o_act.stop      = 1'b1;
                    o_act.wr_en     = 1'b1;
                    o_act.set_valid = 1'b1;
                    o_act.wr_entry  = '{xid: i_xid_issue, tag: i_tag,
                                        timer: 8'd0, retries: 8'd0};
                    o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_ISSUED,
                        i_xid_issue, i_tag, 32'd0, 32'd0, 1'b0);
                end else if (i_last) begin
                    o_act.has_res = 1'b1;
                    o_act.stop    = 1'b1;
                    o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_FULL,
                        i_xid_issue, 16'd0, 32'd0, 32'd0, 1'b0);
                end
            end
            rpcoct_pkg::CMD_MSG: begin
                // Reply lookup: the lowest matching slot is freed.
                if (w_match) begin
                    o_act.has_res   = 1'b1;
                    o_act.stop      = 1'b1;
                    o_act.clr_valid = 1'b1;
                    if (i_rstat != 32'd0) begin
                        o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_COMPLETED,
                            i_mxid, i_entry.tag, i_rstat, rpcoct_pkg::WORD_ONES, 1'b0);
                    end else if (i_herr != rpcoct_pkg::HERR_NONE) begin
                        o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_MALFORMED,
                            i_mxid, i_entry.tag, 32'd0, 32'd0, 1'b0);
                    end else begin
                        o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_COMPLETED,
                            i_mxid, i_entry.tag, 32'd0, i_astat, 1'b1);
                    end
                end else if (i_last) begin
                    o_act.has_res = 1'b1;
                    o_act.stop    = 1'b1;
                    o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_UNKNOWN,
                        i_mxid, 16'd0, 32'd0, 32'd0, 1'b0);
                end
            end
            rpcoct_pkg::CMD_TICK: begin
                // Age the call; at the due point retransmit or time out.
                o_act.stop = i_last;
                if (i_slot_valid) begin
                    o_act.wr_en          = 1'b1;
                    o_act.wr_entry.timer = w_timer_inc;
                    if (w_due) begin
                        o_act.has_res = 1'b1;
                        if (w_expired) begin
                            o_act.clr_valid = 1'b1;
                            o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_TIMEOUT,
                                i_entry.xid, i_entry.tag, rpcoct_pkg::WORD_ONES,
                                rpcoct_pkg::WORD_ONES, 1'b0);
                        end else begin
                            o_act.wr_entry.timer   = 8'd0;
                            o_act.wr_entry.retries = i_entry.retries + 8'd1;
                            o_act.res = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_RETX,
                                i_entry.xid, i_entry.tag, 32'd0, 32'd0, 1'b0);
                        end
                    end
                end
            end
            default: begin
                o_act.stop = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/rpc_outstanding_call_tracker.sv =====
// ----------------------------------------------------------------------------
// RPC outstanding call tracker: top level
// Slot table of pending calls walked by a small sequencer, one slot per unstalled cycle.
// ----------------------------------------------------------------------------
// An issue or reply passes an accept step, a walk up to the deciding slot and a
// flush; a tick walks every slot. Dropped messages go from accept to the flush.
// The walk is bounded by the single read port of the slot memory, one slot a
// cycle; a full output stage stalls the walk. Ready again after the flush.
// Reset (synchronous, active low) clears all slot valid bits, restores the
// registers to 8 and 60 and loads the ID counter with 0; no clearing pass.
// ----------------------------------------------------------------------------
module rpc_outstanding_call_tracker #(
    parameter int SLOTS = rpcoct_pkg::SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: call_tag[15:0], msg_xid[47:16], reply_status[79:48],
    //        accept_status[111:80], header_error[113:112], zero fill[119:114]
    input  logic [119:0] i_s_tdata,
    // tuser: cmd[1:0], msg_is_reply[2]
    input  logic [2:0]   i_s_tuser,
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: xid[31:0], tag[47:32], status_out[79:48], accept_out[111:80]
    output logic [111:0] o_m_tdata,
    // tuser: kind[2:0], accept_valid[3]
    output logic [3:0]   o_m_tuser,
    output logic         o_m_tlast,
    // Configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    // Sequencer and command registers.
    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [1:0]          r_cmd, n_cmd;
    logic [15:0]         r_tag, n_tag;
    logic [31:0]         r_mxid, n_mxid;
    logic [31:0]         r_rstat, n_rstat;
    logic [31:0]         r_astat, n_astat;
    logic [1:0]          r_herr, n_herr;
    logic [31:0]         r_xid_issue, n_xid_issue;
    logic [SLOTS-1:0]    r_valid, n_valid;
    logic [7:0]          r_retx_after, n_retx_after;
    logic [7:0]          r_max_retx, n_max_retx;
    logic [31:0]         r_next_xid, n_next_xid;
    // Held-back result, so that the final one of an item can carry last.
    rpcoct_pkg::t_result r_pend, n_pend;
    logic                r_pend_valid, n_pend_valid;
    // Output register.
    rpcoct_pkg::t_result r_out, n_out;
    logic                r_out_last, n_out_last;
    logic                r_out_valid, n_out_valid;

    // Input field unpacking.
    logic [1:0]  w_cmd;
    logic        w_is_reply;
    logic [15:0] w_tag;
    logic [31:0] w_mxid;
    logic [31:0] w_rstat;
    logic [31:0] w_astat;
    logic [1:0]  w_herr;

    assign w_cmd      = i_s_tuser[1:0];
    assign w_is_reply = i_s_tuser[2];
    assign w_tag      = i_s_tdata[15:0];
    assign w_mxid     = i_s_tdata[47:16];
    assign w_rstat    = i_s_tdata[79:48];
    assign w_astat    = i_s_tdata[111:80];
    assign w_herr     = i_s_tdata[113:112];

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_last_idx;
    logic                    w_stall;
    logic                    w_step;
    logic                    w_rd_en;
    logic [IW-1:0]           w_rd_addr;
    rpcoct_pkg::t_slot_entry w_rd_data;
    rpcoct_pkg::t_slot_act   w_act;
    logic                    w_push;
    rpcoct_pkg::t_result     w_push_res;
    logic                    w_push_last;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last_idx = (r_idx == IW'(SLOTS - 1));

    // Slot memory, read one slot ahead of the evaluation.
    rpcoct_slot_ram #(
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_step && w_act.wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_act.wr_entry),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Shared compare and update unit for the slot under evaluation.
    rpcoct_slot_unit u_unit (
        .i_op         (r_cmd),
        .i_slot_valid (r_valid[r_idx]),
        .i_entry      (w_rd_data),
        .i_last       (w_last_idx),
        .i_xid_issue  (r_xid_issue),
        .i_tag        (r_tag),
        .i_mxid       (r_mxid),
        .i_rstat      (r_rstat),
        .i_astat      (r_astat),
        .i_herr       (r_herr),
        .i_retx_after (r_retx_after),
        .i_max_retx   (r_max_retx),
        .o_act        (w_act)
    );

    // A new result with one already held needs room in the output register.
    assign w_stall   = w_act.has_res && r_pend_valid && !w_out_free;
    assign w_step    = (r_state == S_WALK) && !w_stall;
    assign w_rd_en   = w_accept || (w_step && !w_act.stop);
    assign w_rd_addr = w_accept ? '0 : r_idx + IW'(1);

    // Sequencer next state.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmd        = r_cmd;
        n_tag        = r_tag;
        n_mxid       = r_mxid;
        n_rstat      = r_rstat;
        n_astat      = r_astat;
        n_herr       = r_herr;
        n_xid_issue  = r_xid_issue;
        n_valid      = r_valid;
        n_retx_after = r_retx_after;
        n_max_retx   = r_max_retx;
        n_next_xid   = r_next_xid;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        w_push       = 1'b0;
        w_push_res   = r_pend;
        w_push_last  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = w_cmd;
                    n_tag   = w_tag;
                    n_mxid  = w_mxid;
                    n_rstat = w_rstat;
                    n_astat = w_astat;
                    n_herr  = w_herr;
                    n_idx   = '0;
                    case (w_cmd)
                        rpcoct_pkg::CMD_ISSUE: begin
                            n_xid_issue = r_next_xid;
                            n_next_xid  = r_next_xid + 32'd1;
                            n_state     = S_WALK;
                        end
                        rpcoct_pkg::CMD_MSG: begin
                            if (w_herr == rpcoct_pkg::HERR_SHORT) begin
                                n_pend = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_DROPPED,
                                    32'd0, 16'd0, 32'd0, 32'd0, 1'b0);
                                n_pend_valid = 1'b1;
                                n_state      = S_FLUSH;
                            end else if (!w_is_reply) begin
                                n_pend = rpcoct_pkg::mk_result(rpcoct_pkg::KIND_DROPPED,
                                    w_mxid, 16'd0, 32'd0, 32'd0, 1'b0);
                                n_pend_valid = 1'b1;
                                n_state      = S_FLUSH;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        rpcoct_pkg::CMD_TICK: begin
                            n_state = S_WALK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (w_step) begin
                    if (w_act.set_valid) begin
                        n_valid[r_idx] = 1'b1;
                    end
                    if (w_act.clr_valid) begin
                        n_valid[r_idx] = 1'b0;
                    end
                    if (w_act.has_res) begin
                        w_push       = r_pend_valid;
                        n_pend       = w_act.res;
                        n_pend_valid = 1'b1;
                    end
                    if (w_act.stop) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    w_push       = 1'b1;
                    w_push_last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The user must send configuration writes only while idle; the block does not enforce it.
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rpcoct_pkg::REG_RETX_AFTER: n_retx_after = i_cfg_data[7:0];
                rpcoct_pkg::REG_MAX_RETX:   n_max_retx   = i_cfg_data[7:0];
                rpcoct_pkg::REG_XID_SEED:   n_next_xid   = i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Output register next state.
    always_comb begin
        n_out      = r_out;
        n_out_last = r_out_last;
        if (w_push) begin
            n_out       = w_push_res;
            n_out_last  = w_push_last;
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_cmd        <= rpcoct_pkg::CMD_NONE;
            r_valid      <= '0;
            r_retx_after <= rpcoct_pkg::RETX_AFTER_RST;
            r_max_retx   <= rpcoct_pkg::MAX_RETX_RST;
            r_next_xid   <= rpcoct_pkg::XID_SEED_RST;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmd        <= n_cmd;
            r_valid      <= n_valid;
            r_retx_after <= n_retx_after;
            r_max_retx   <= n_max_retx;
            r_next_xid   <= n_next_xid;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_tag       <= n_tag;
        r_mxid      <= n_mxid;
        r_rstat     <= n_rstat;
        r_astat     <= n_astat;
        r_herr      <= n_herr;
        r_xid_issue <= n_xid_issue;
        r_pend      <= n_pend;
        r_out       <= n_out;
        r_out_last  <= n_out_last;
    end

    // Result stream packing.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {r_out.accept, r_out.status, r_out.tag, r_out.xid};
    assign o_m_tuser  = {r_out.accept_valid, r_out.kind};

    // The table is written only while a walk advances.
    a_wr_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_act.wr_en) |-> (r_state == S_WALK))
        else $error("slot write outside a walk");

    // No result of a finished item is left behind when a new one may enter.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_pend_valid)
        else $error("held result left over while ready");

    // An issue walk holds no result until the slot decision is made.
    a_issue_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (r_cmd == rpcoct_pkg::CMD_ISSUE)) |-> !r_pend_valid)
        else $error("issue walk holds a result");

    // A flushed result always goes out marked as the final one.
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FLUSH) && r_pend_valid && w_out_free) |=>
        (o_m_tvalid && o_m_tlast && (r_state == S_IDLE)))
        else $error("flush did not deliver a final result");

    // The unused command code causes no work at all.
    a_cmd_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == rpcoct_pkg::CMD_NONE)) |=> (r_state == S_IDLE))
        else $error("unused command started a walk");

endmodule

// ===== sim/rpc_outstanding_call_tracker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPC outstanding call tracker: testbench
// Drives issue, reply and tick commands in bursts against a bit-exact
// predictor of the slot table and checks every result transfer in order.
// ----------------------------------------------------------------------------
module rpc_outstanding_call_tracker_test;

    localparam int N_SLOTS         = rpcoct_pkg::SLOTS_DEF;
    // A tick walks every slot plus accept and flush; leave margin on top.
    localparam int SETTLE_CYCLES   = 2 * (N_SLOTS + 2) + 4;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RECENT_DEPTH    = 24;

    // Register index with no register behind it.
    localparam logic [1:0] REG_SPARE = 2'd3;
    // Header error codes beyond the ones the package names.
    localparam logic [1:0] HERR_BAD  = 2'd2;
    localparam logic [1:0] HERR_ODD  = 2'd3;

    // One command on the input side.
    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] tag;
        logic [31:0] xid;
        logic        is_reply;
        logic [31:0] rstat;
        logic [31:0] astat;
        logic [1:0]  herr;
    } t_call_cmd;

    // One result as it appears on the output side.
    typedef struct {
        rpcoct_pkg::t_result res;
        logic                last;
    } t_call_result;

    typedef enum {RX_FREE, RX_COIN, RX_SPARSE} t_rx_mode;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [119:0] i_s_tdata   = '0;
    logic [2:0]   i_s_tuser   = '0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [111:0] o_m_tdata;
    logic [3:0]   o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data  = '0;

    rpc_outstanding_call_tracker #(
        .SLOTS (N_SLOTS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted slot table, registers and ID counter.
    logic        call_live [N_SLOTS] = '{default: 1'b0};
    logic [31:0] call_xid  [N_SLOTS];
    logic [15:0] call_tag  [N_SLOTS];
    logic [7:0]  call_age  [N_SLOTS];
    logic [7:0]  call_retx [N_SLOTS];
    logic [31:0] id_counter = rpcoct_pkg::XID_SEED_RST;
    logic [7:0]  retx_after = rpcoct_pkg::RETX_AFTER_RST;
    logic [7:0]  retx_limit = rpcoct_pkg::MAX_RETX_RST;

    t_call_cmd    pending_cmds[$];
    t_call_result expected_results[$];

    // Stimulus side view of the ID counter, so replies can hit live calls.
    logic [31:0]  gen_next_xid = rpcoct_pkg::XID_SEED_RST;
    logic [31:0]  recent_xids[$];

    int           failures = 0;

    function automatic void expect_result(input logic [2:0] kind, input logic [31:0] xid,
                                          input logic [15:0] tag, input logic [31:0] status,
                                          input logic [31:0] accept, input logic acc_valid);
        t_call_result r;
        r.res.kind         = kind;
        r.res.xid          = xid;
        r.res.tag          = tag;
        r.res.status       = status;
        r.res.accept       = accept;
        r.res.accept_valid = acc_valid;
        r.last             = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Apply one accepted command to the predicted table and queue its results.
    function automatic void predict_call_results(input t_call_cmd c);
        int           slot;
        int           n_before;
        logic [31:0]  issued;
        t_call_result tail;
        n_before = expected_results.size();
        slot     = N_SLOTS;
        case (c.cmd)
            rpcoct_pkg::CMD_ISSUE: begin
                issued     = id_counter;
                id_counter = id_counter + 32'd1;
                for (int i = N_SLOTS - 1; i >= 0; i--) begin
                    if (!call_live[i]) slot = i;
                end
                if (slot < N_SLOTS) begin
                    call_live[slot] = 1'b1;
                    call_xid[slot]  = issued;
                    call_tag[slot]  = c.tag;
                    call_age[slot]  = 8'd0;
                    call_retx[slot] = 8'd0;
                    expect_result(rpcoct_pkg::KIND_ISSUED, issued, c.tag, '0, '0, 1'b0);
                end else begin
                    expect_result(rpcoct_pkg::KIND_FULL, issued, '0, '0, '0, 1'b0);
                end
            end
            rpcoct_pkg::CMD_MSG: begin
                if (c.herr == rpcoct_pkg::HERR_SHORT) begin
                    expect_result(rpcoct_pkg::KIND_DROPPED, '0, '0, '0, '0, 1'b0);
                end else if (!c.is_reply) begin
                    expect_result(rpcoct_pkg::KIND_DROPPED, c.xid, '0, '0, '0, 1'b0);
                end else begin
                    // Lowest matching slot wins when an XID is stored twice.
                    for (int i = N_SLOTS - 1; i >= 0; i--) begin
                        if (call_live[i] && call_xid[i] == c.xid) slot = i;
                    end
                    if (slot == N_SLOTS) begin
                        expect_result(rpcoct_pkg::KIND_UNKNOWN, c.xid, '0, '0, '0, 1'b0);
                    end else begin
                        call_live[slot] = 1'b0;
                        if (c.rstat != '0) begin
                            expect_result(rpcoct_pkg::KIND_COMPLETED, c.xid, call_tag[slot],
                                          c.rstat, rpcoct_pkg::WORD_ONES, 1'b0);
                        end else if (c.herr != rpcoct_pkg::HERR_NONE) begin
                            expect_result(rpcoct_pkg::KIND_MALFORMED, c.xid, call_tag[slot],
                                          '0, '0, 1'b0);
                        end else begin
                            expect_result(rpcoct_pkg::KIND_COMPLETED, c.xid, call_tag[slot],
                                          '0, c.astat, 1'b1);
                        end
                    end
                end
            end
            rpcoct_pkg::CMD_TICK: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (call_live[i]) begin
                        if (call_age[i] != rpcoct_pkg::TIMER_TOP) begin
                            call_age[i] = call_age[i] + 8'd1;
                        end
                        if (call_age[i] >= retx_after) begin
                            if (call_retx[i] >= retx_limit) begin
                                call_live[i] = 1'b0;
                                expect_result(rpcoct_pkg::KIND_TIMEOUT, call_xid[i],
                                              call_tag[i], rpcoct_pkg::WORD_ONES,
                                              rpcoct_pkg::WORD_ONES, 1'b0);
                            end else begin
                                call_retx[i] = call_retx[i] + 8'd1;
                                call_age[i]  = 8'd0;
                                expect_result(rpcoct_pkg::KIND_RETX, call_xid[i], call_tag[i],
                                              '0, '0, 1'b0);
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        // The final result of this command carries the last flag.
        if (expected_results.size() > n_before) begin
            tail      = expected_results.pop_back();
            tail.last = 1'b1;
            expected_results.push_back(tail);
        end
    endfunction

    function automatic void queue_cmd(input logic [1:0] cmd, input logic [15:0] tag,
                                      input logic [31:0] xid, input logic is_reply,
                                      input logic [31:0] rstat, input logic [31:0] astat,
                                      input logic [1:0] herr);
        t_call_cmd c;
        c.cmd      = cmd;
        c.tag      = tag;
        c.xid      = xid;
        c.is_reply = is_reply;
        c.rstat    = rstat;
        c.astat    = astat;
        c.herr     = herr;
        pending_cmds.push_back(c);
        // Every issue consumes an XID, even when the table is full.
        if (cmd == rpcoct_pkg::CMD_ISSUE) begin
            recent_xids.push_back(gen_next_xid);
            if (recent_xids.size() > RECENT_DEPTH) void'(recent_xids.pop_front());
            gen_next_xid = gen_next_xid + 32'd1;
        end
    endfunction

    function automatic void queue_issue(input logic [15:0] tag);
        queue_cmd(rpcoct_pkg::CMD_ISSUE, tag, $urandom, 1'($urandom_range(0, 1)), $urandom,
                  $urandom, 2'($urandom_range(0, 3)));
    endfunction

    function automatic void queue_reply(input logic [31:0] xid, input logic [31:0] rstat,
                                        input logic [31:0] astat, input logic [1:0] herr);
        queue_cmd(rpcoct_pkg::CMD_MSG, 16'($urandom), xid, 1'b1, rstat, astat, herr);
    endfunction

    function automatic void queue_ticks(input int count);
        for (int k = 0; k < count; k++) begin
            queue_cmd(rpcoct_pkg::CMD_TICK, 16'($urandom), $urandom,
                      1'($urandom_range(0, 1)), $urandom, $urandom,
                      2'($urandom_range(0, 3)));
        end
    endfunction

    // Mostly issues and replies to recent XIDs, with ticks and stray messages.
    function automatic void queue_random_traffic(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                queue_issue(16'($urandom));
            end else if (pick < 65 && recent_xids.size() != 0) begin
                queue_reply(recent_xids[$urandom_range(0, recent_xids.size() - 1)],
                            ($urandom_range(0, 3) == 0) ? $urandom : 32'd0, $urandom,
                            ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) :
                                                          rpcoct_pkg::HERR_NONE);
            end else if (pick < 82) begin
                queue_ticks(1);
            end else begin
                queue_cmd(2'($urandom_range(1, 3)), 16'($urandom), $urandom,
                          1'($urandom_range(0, 1)), $urandom, $urandom,
                          2'($urandom_range(0, 3)));
            end
        end
    endfunction

    // Input driver: bursts of transfers separated by random gaps.
    int        burst_left = 1;
    int        gap_left   = 0;
    t_call_cmd on_bus;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_call_results(on_bus);
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            // An offered command stays on the bus until it is taken.
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    on_bus = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {6'b0, on_bus.herr, on_bus.astat, on_bus.rstat,
                                   on_bus.xid, on_bus.tag};
                    i_s_tuser  <= {on_bus.is_reply, on_bus.cmd};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: changing stall patterns, plus a long hold-off on request.
    t_rx_mode rx_mode      = RX_FREE;
    int       rx_mode_left = 0;
    int       rx_hold_left = 0;
    bit       rx_hold_req  = 1'b0;

    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = HOLD_OFF_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(16, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_FREE:  i_m_tready <= 1'b1;
                RX_COIN:  i_m_tready <= 1'($urandom_range(0, 1));
                default:  i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Result checker: each transfer against the oldest expectation.
    t_call_result seen_result;
    t_call_result want_result;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_result.res.xid          = o_m_tdata[31:0];
            seen_result.res.tag          = o_m_tdata[47:32];
            seen_result.res.status       = o_m_tdata[79:48];
            seen_result.res.accept       = o_m_tdata[111:80];
            seen_result.res.kind         = o_m_tuser[2:0];
            seen_result.res.accept_valid = o_m_tuser[3];
            seen_result.last             = o_m_tlast;
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: result with nothing pending: kind %0d xid %h tag %h",
                         $time, seen_result.res.kind, seen_result.res.xid,
                         seen_result.res.tag);
            end else begin
                want_result = expected_results.pop_front();
                if (seen_result.res.kind !== want_result.res.kind ||
                    seen_result.res.xid !== want_result.res.xid ||
                    seen_result.res.tag !== want_result.res.tag ||
                    seen_result.res.status !== want_result.res.status ||
                    seen_result.res.accept !== want_result.res.accept ||
                    seen_result.res.accept_valid !== want_result.res.accept_valid ||
                    seen_result.last !== want_result.last) begin
                    failures++;
                    $display("%0t: expected kind %0d xid %h tag %h st %h acc %h av %b last %b",
                             $time, want_result.res.kind, want_result.res.xid,
                             want_result.res.tag, want_result.res.status,
                             want_result.res.accept, want_result.res.accept_valid,
                             want_result.last);
                    $display("%0t: actual   kind %0d xid %h tag %h st %h acc %h av %b last %b",
                             $time, seen_result.res.kind, seen_result.res.xid,
                             seen_result.res.tag, seen_result.res.status,
                             seen_result.res.accept, seen_result.res.accept_valid,
                             seen_result.last);
                end
            end
        end
    end

    // Wait until every command is taken and every result is back, then let
    // any walk that produces no result finish.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_cmds.size() != 0 || i_s_tvalid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (index)
            rpcoct_pkg::REG_RETX_AFTER: retx_after = value[7:0];
            rpcoct_pkg::REG_MAX_RETX:   retx_limit = value[7:0];
            rpcoct_pkg::REG_XID_SEED: begin
                id_counter   = value;
                gen_next_xid = value;
            end
            default: begin
            end
        endcase
    endtask

    // Test sequence.
    initial begin
        logic [31:0] dup_seed;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, every command and every message outcome.
        @(negedge i_clk);
        queue_issue(16'h0000);
        queue_issue(16'hFFFF);
        queue_issue(16'($urandom));
        queue_ticks(1);
        queue_cmd(rpcoct_pkg::CMD_NONE, 16'($urandom), $urandom, 1'b1, $urandom, $urandom,
                  rpcoct_pkg::HERR_NONE);
        queue_cmd(rpcoct_pkg::CMD_MSG, 16'($urandom), 32'hFFFF_FFFF, 1'b0, $urandom,
                  $urandom, rpcoct_pkg::HERR_NONE);
        queue_cmd(rpcoct_pkg::CMD_MSG, 16'($urandom), 32'd0, 1'b1, 32'd0, $urandom,
                  rpcoct_pkg::HERR_SHORT);
        queue_reply(32'h8000_0000, 32'd0, $urandom, rpcoct_pkg::HERR_NONE);
        queue_reply(32'd0, 32'd0, 32'hFFFF_FFFF, rpcoct_pkg::HERR_NONE);
        queue_reply(32'd1, 32'hFFFF_FFFF, $urandom, HERR_BAD);
        queue_reply(32'd2, 32'd0, $urandom, HERR_BAD);
        queue_issue(16'($urandom));
        queue_reply(32'd3, 32'd0, $urandom, HERR_ODD);
        queue_issue(16'($urandom));
        queue_ticks(8);
        wait_drained();

        // Registers at their extremes; the pending call already retried once,
        // so a zero retry limit times it out on the next tick.
        write_reg(rpcoct_pkg::REG_RETX_AFTER, 32'd0);
        write_reg(rpcoct_pkg::REG_MAX_RETX, 32'd0);
        write_reg(rpcoct_pkg::REG_XID_SEED, 32'hFFFF_FFFF);
        write_reg(REG_SPARE, $urandom);
        @(negedge i_clk);
        queue_issue(16'($urandom));
        queue_issue(16'($urandom));
        queue_ticks(1);
        wait_drained();

        // Fill the table past full, then retransmit every slot until timeout.
        write_reg(rpcoct_pkg::REG_RETX_AFTER, 32'd1);
        write_reg(rpcoct_pkg::REG_MAX_RETX, 32'd2);
        write_reg(rpcoct_pkg::REG_XID_SEED, $urandom);
        @(negedge i_clk);
        for (int k = 0; k <= N_SLOTS; k++) queue_issue(16'($urandom));
        queue_ticks(3);
        wait_drained();

        // Same XID stored twice: replies free the lower slot first.
        dup_seed = $urandom;
        write_reg(rpcoct_pkg::REG_XID_SEED, dup_seed);
        @(negedge i_clk);
        queue_issue(16'($urandom));
        queue_issue(16'($urandom));
        wait_drained();
        write_reg(rpcoct_pkg::REG_XID_SEED, dup_seed);
        @(negedge i_clk);
        queue_issue(16'($urandom));
        queue_reply(dup_seed, 32'd0, $urandom, rpcoct_pkg::HERR_NONE);
        queue_reply(dup_seed, $urandom, $urandom, rpcoct_pkg::HERR_NONE);
        queue_reply(dup_seed + 32'd1, 32'd0, $urandom, rpcoct_pkg::HERR_NONE);
        wait_drained();

        // Long timer: one retransmit after 20 ticks, timeout after 20 more.
        write_reg(rpcoct_pkg::REG_RETX_AFTER, 32'd20);
        write_reg(rpcoct_pkg::REG_MAX_RETX, 32'd1);
        @(negedge i_clk);
        queue_issue(16'($urandom));
        queue_ticks(40);
        wait_drained();

        // Random traffic under several settings.
        write_reg(rpcoct_pkg::REG_RETX_AFTER, $urandom_range(1, 4));
        write_reg(rpcoct_pkg::REG_MAX_RETX, $urandom_range(0, 3));
        write_reg(rpcoct_pkg::REG_XID_SEED, $urandom);
        @(negedge i_clk);
        queue_random_traffic(28);
        wait_drained();

        // Receiver holds off while commands keep coming, so the block backs up.
        write_reg(rpcoct_pkg::REG_RETX_AFTER, 32'd255);
        write_reg(rpcoct_pkg::REG_MAX_RETX, 32'd255);
        write_reg(rpcoct_pkg::REG_XID_SEED, $urandom);
        @(negedge i_clk);
        rx_hold_req = 1'b1;
        queue_random_traffic(28);
        wait_drained();

        write_reg(rpcoct_pkg::REG_RETX_AFTER, 32'd1);
        write_reg(rpcoct_pkg::REG_MAX_RETX, $urandom_range(0, 2));
        @(negedge i_clk);
        queue_random_traffic(28);
        wait_drained();

        write_reg(rpcoct_pkg::REG_RETX_AFTER, $urandom_range(1, 8));
        write_reg(rpcoct_pkg::REG_MAX_RETX, $urandom_range(0, 8));
        write_reg(rpcoct_pkg::REG_XID_SEED, 32'hFFFF_FFF0);
        @(negedge i_clk);
        queue_random_traffic(28);
        wait_drained();

        if (failures == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog well above the slowest legal run.
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== rpc_outstanding_call_tracker.f =====
sv/rpcoct_pkg.sv
sv/rpcoct_slot_ram.sv
sv/rpcoct_slot_unit.sv
sv/rpc_outstanding_call_tracker.sv
sim/rpc_outstanding_call_tracker_test.sv
